### rtl/mts_pkg.sv
// Shared types, codes and constants of the max tracking stack.
package mts_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 7;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [STATUS_W-1:0]       status_t;
    typedef logic [ENTRY_W-1:0]        entry_t;
    typedef logic                      func_t;

    localparam func_t FUNC_PUSH = 1'b0;
    localparam func_t FUNC_POP  = 1'b1;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_UNDERFLOW = 2'd1;
    localparam status_t ST_OVERFLOW  = 2'd2;

    localparam value_t NEG_ONE = 32'shFFFF_FFFF;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // latch the word and read the entries below the tops
        logic exec;   // update the stacks and load the result register
    } ctrl_cmd_t;

endpackage

### rtl/mts_if.sv
// Handshake interfaces for the operation and result channels.
interface mts_in_if;
    logic            valid;
    logic            ready;
    mts_pkg::func_t  func;
    mts_pkg::value_t push_value;

    modport source (output valid, output func, output push_value, input ready);
    modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface mts_out_if;
    logic             valid;
    logic             ready;
    mts_pkg::value_t  popped_value;
    mts_pkg::value_t  current_max;
    mts_pkg::status_t status;
    mts_pkg::entry_t  entry_count;

    modport source (output valid, output popped_value, output current_max,
                    output status, output entry_count, input ready);
    modport sink   (input valid, input popped_value, input current_max,
                    input status, input entry_count, output ready);
endinterface

### rtl/max_tracking_stack.sv
// Max tracking stack: a LIFO of signed 32-bit values that reports its maximum.
// Each operation word is a push or a pop and returns one result word with the
// popped value, the maximum after the operation, a status and the entry count.
// In the accept cycle an operation reads the entries just below the value and
// maxima tops from the synchronous-read stores; then the EXEC state updates
// counts and tops, writes the stores and loads the result register. The
// result register is separate, so a new operation is taken while an earlier
// result waits; an operation that finds that register still full holds in the
// EXEC state until the result is taken. A pop on an empty stack reports
// underflow with -1 for value and maximum; a push on a full stack is dropped
// and reports overflow. No clearing pass is needed after reset.
module max_tracking_stack
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic             clk,
    input  logic             rst_n,
    mts_in_if.sink           ops,
    mts_out_if.source        results
);

    mts_pkg::ctrl_cmd_t cmd;

    mts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ops.valid),
        .in_ready  (ops.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    mts_dp
    #(
        .STACK_DEPTH (STACK_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (ops.func),
        .push_value   (ops.push_value),
        .popped_value (results.popped_value),
        .current_max  (results.current_max),
        .status       (results.status),
        .entry_count  (results.entry_count)
    );

endmodule

### rtl/mts_ctrl.sv
// Controller: sequences each operation and owns the result valid flag.
module mts_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output mts_pkg::ctrl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic accept;
    logic exec;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // hold in EXEC until the result register is free or being emptied
    assign exec     = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = exec ? 1'b1 : (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign cmd.load  = accept;
    assign cmd.exec  = exec;

endmodule

### rtl/mts_dp.sv
// Datapath: value and maxima stores, top registers, counts and result register.
module mts_dp
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mts_pkg::ctrl_cmd_t cmd,
    input  mts_pkg::func_t     func,
    input  mts_pkg::value_t    push_value,
    output mts_pkg::value_t    popped_value,
    output mts_pkg::value_t    current_max,
    output mts_pkg::status_t   status,
    output mts_pkg::entry_t    entry_count
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    mts_pkg::value_t value_mem [STACK_DEPTH];
    mts_pkg::value_t max_mem   [STACK_DEPTH];

    mts_pkg::func_t   func_reg;
    mts_pkg::value_t  val_reg;
    mts_pkg::value_t  vrd_reg;
    mts_pkg::value_t  mrd_reg;

    logic [CW-1:0]    vcount_reg;
    logic [CW-1:0]    vcount_next;
    logic [CW-1:0]    mcount_reg;
    logic [CW-1:0]    mcount_next;
    mts_pkg::value_t  vtop_reg;
    mts_pkg::value_t  vtop_next;
    mts_pkg::value_t  mtop_reg;
    mts_pkg::value_t  mtop_next;

    mts_pkg::value_t  popped_reg;
    mts_pkg::value_t  popped_next;
    mts_pkg::value_t  max_reg;
    mts_pkg::value_t  max_next;
    mts_pkg::status_t status_reg;
    mts_pkg::status_t status_next;
    mts_pkg::entry_t  entry_reg;

    logic             v_we;
    logic             m_we;
    logic [CW-1:0]    vbelow;
    logic [CW-1:0]    mbelow;

    // entries just below the tops feed the top registers after a pop
    assign vbelow = vcount_reg - CW'(2);
    assign mbelow = mcount_reg - CW'(2);

    always_comb
    begin
        vcount_next = vcount_reg;
        mcount_next = mcount_reg;
        vtop_next   = vtop_reg;
        mtop_next   = mtop_reg;
        popped_next = '0;
        max_next    = mts_pkg::NEG_ONE;
        status_next = mts_pkg::ST_OK;
        v_we        = 1'b0;
        m_we        = 1'b0;
        case (func_reg)
            mts_pkg::FUNC_PUSH:
            begin
                if (vcount_reg == FULL)
                begin
                    status_next = mts_pkg::ST_OVERFLOW;
                    max_next    = (mcount_reg == '0) ? mts_pkg::NEG_ONE : mtop_reg;
                end
                else
                begin
                    v_we        = 1'b1;
                    vcount_next = vcount_reg + CW'(1);
                    vtop_next   = val_reg;
                    // equal values go on the maxima stack too
                    if ((mcount_reg == '0) || (val_reg >= mtop_reg))
                    begin
                        m_we        = 1'b1;
                        mcount_next = mcount_reg + CW'(1);
                        mtop_next   = val_reg;
                    end
                    max_next = mtop_next;
                end
            end
            mts_pkg::FUNC_POP:
            begin
                if (vcount_reg == '0)
                begin
                    status_next = mts_pkg::ST_UNDERFLOW;
                    popped_next = mts_pkg::NEG_ONE;
                end
                else
                begin
                    popped_next = vtop_reg;
                    vcount_next = vcount_reg - CW'(1);
                    vtop_next   = vrd_reg;
                    if ((mcount_reg != '0) && (mtop_reg == vtop_reg))
                    begin
                        mcount_next = mcount_reg - CW'(1);
                        mtop_next   = mrd_reg;
                    end
                    if ((vcount_next != '0) && (mcount_next != '0))
                    begin
                        max_next = mtop_next;
                    end
                end
            end
            default:
            begin
                status_next = mts_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            val_reg  <= push_value;
            vrd_reg  <= value_mem[vbelow[AW-1:0]];
            mrd_reg  <= max_mem[mbelow[AW-1:0]];
        end
        if (cmd.exec && v_we)
        begin
            value_mem[vcount_reg[AW-1:0]] <= val_reg;
        end
        if (cmd.exec && m_we)
        begin
            max_mem[mcount_reg[AW-1:0]] <= val_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            vtop_reg   <= vtop_next;
            mtop_reg   <= mtop_next;
            popped_reg <= popped_next;
            max_reg    <= max_next;
            status_reg <= status_next;
            entry_reg  <= mts_pkg::ENTRY_W'(vcount_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= '0;
            mcount_reg <= '0;
        end
        else if (cmd.exec)
        begin
            vcount_reg <= vcount_next;
            mcount_reg <= mcount_next;
        end
    end

    assign popped_value = popped_reg;
    assign current_max  = max_reg;
    assign status       = status_reg;
    assign entry_count  = entry_reg;

endmodule
